FILE: src/mf3_pkg.sv
// Shared types, constants and median network helpers for the 3x3 RGB median filter.
// Used by median_filter_3x3_rgb; no other dependencies.
`timescale 1ns / 1ps

package mf3_pkg;

    // Field widths of the pixel and result items.
    localparam int CHAN_W        = 8;
    localparam int PIX_W         = 3 * CHAN_W;
    localparam int CFG_W         = 11;
    localparam int COL_OUT_W     = 10;
    localparam int WIN_SIZE      = 9;

    // Defaults for the top-level parameter and the width register, and its lower clamp.
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int WIDTH_RESET   = 640;
    localparam int MIN_WIDTH     = 3;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [PIX_W-1:0]  pixel_t;
    typedef chan_t  [WIN_SIZE-1:0] chan_win_t;
    typedef pixel_t [WIN_SIZE-1:0] pix_win_t;

    // Compare and swap so that the lower value lands at index a.
    function automatic chan_win_t cas(chan_win_t v, int a, int b);
        chan_win_t r;
        r = v;
        if (v[a] > v[b])
        begin
            r[a] = v[b];
            r[b] = v[a];
        end
        return r;
    endfunction

    // First part of the network: sorts each row of three.
    function automatic chan_win_t sort_rows(chan_win_t v);
        chan_win_t r;
        r = v;
        r = cas(r, 1, 2); r = cas(r, 4, 5); r = cas(r, 7, 8);
        r = cas(r, 0, 1); r = cas(r, 3, 4); r = cas(r, 6, 7);
        r = cas(r, 1, 2); r = cas(r, 4, 5); r = cas(r, 7, 8);
        return r;
    endfunction

    // Second part of the network: picks the median out of sorted rows.
    function automatic chan_t median_tail(chan_win_t v);
        chan_win_t r;
        r = v;
        r = cas(r, 0, 3); r = cas(r, 5, 8); r = cas(r, 4, 7);
        r = cas(r, 3, 6); r = cas(r, 1, 4); r = cas(r, 2, 5);
        r = cas(r, 4, 7); r = cas(r, 4, 2); r = cas(r, 6, 4);
        r = cas(r, 4, 2);
        return r[4];
    endfunction

    // Pulls one color channel out of a pixel window.
    function automatic chan_win_t channel_of(pix_win_t w, int ch);
        chan_win_t r;
        for (int i = 0; i < WIN_SIZE; i++)
        begin
            r[i] = w[i][ch*CHAN_W +: CHAN_W];
        end
        return r;
    endfunction

endpackage

FILE: src/median_filter_3x3_rgb.sv
// 3x3 per-channel median filter over a raster stream of 24-bit RGB pixels.
// A window's result passes stage 1, window snapshot, row sort and output register in that order.
// One item per cycle unless stalled; the line-store RAM is read once and written once per item.
// Reset: counters, valids and the width register (640) clear at once; line stores and the
// window hold undefined data until written, with no clearing pass.
// Depends on mf3_pkg and mf3_ram.
`timescale 1ns / 1ps

module median_filter_3x3_rgb #(
    parameter int MAX_WIDTH = mf3_pkg::DEF_MAX_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Width register write port.
    input  logic                          cfg_wen,
    input  logic [mf3_pkg::CFG_W-1:0]     cfg_wdata,
    // Pixel input channel.
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mf3_pkg::CHAN_W-1:0]    in_red,
    input  logic [mf3_pkg::CHAN_W-1:0]    in_green,
    input  logic [mf3_pkg::CHAN_W-1:0]    in_blue,
    input  logic                          frame_start,
    // Result output channel.
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mf3_pkg::CHAN_W-1:0]    out_red,
    output logic [mf3_pkg::CHAN_W-1:0]    out_green,
    output logic [mf3_pkg::CHAN_W-1:0]    out_blue,
    output logic [mf3_pkg::COL_OUT_W-1:0] centre_column,
    output logic                          row_end
);

    import mf3_pkg::*;

    localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > CFG_W) ? WW : CFG_W;
    localparam int LW   = 2 * PIX_W;

    // Channel positions inside a packed pixel.
    localparam int CH_RED   = 2;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 0;

    // Control and configuration state.
    logic [CFG_W-1:0] width_reg;
    logic [AW-1:0]    col_reg;
    logic [1:0]       row_reg;

    // Stage 1: item waits for its line-store read data.
    logic             s1_valid_reg;
    pixel_t           s1_pixel_reg;
    logic [AW-1:0]    s1_col_reg;
    logic             s1_emit_reg;
    logic             s1_row_end_reg;
    logic [AW-1:0]    s1_centre_reg;
    logic             s1_fwd_reg;
    logic [LW-1:0]    s1_fwd_data_reg;

    // Stage 2: snapshot of a complete window.
    logic             s2_valid_reg;
    pix_win_t         s2_win_reg;
    logic             s2_row_end_reg;
    logic [AW-1:0]    s2_centre_reg;

    // Stage 3: rows sorted per channel.
    logic             s3_valid_reg;
    chan_win_t        s3_red_reg;
    chan_win_t        s3_green_reg;
    chan_win_t        s3_blue_reg;
    logic             s3_row_end_reg;
    logic [AW-1:0]    s3_centre_reg;

    // Output register.
    logic             out_valid_reg;
    chan_t            out_red_reg;
    chan_t            out_green_reg;
    chan_t            out_blue_reg;
    logic [AW-1:0]    out_centre_reg;
    logic             out_row_end_reg;

    // Sliding window of the filter.
    pix_win_t         win_reg;
    pix_win_t         win_next;

    logic [WW-1:0]    eff_width;
    logic [CMPW-1:0]  width_ext;
    logic             accept;
    logic [AW-1:0]    acc_col;
    logic [1:0]       acc_row;
    logic [WW-1:0]    acc_col_inc;
    logic             acc_emit;
    logic             acc_row_end;
    logic [AW-1:0]    col_next;
    logic [1:0]       row_next;

    logic             out_adv;
    logic             s3_free;
    logic             s2_free;
    logic             s1_adv;

    logic [LW-1:0]    ram_rd_data;
    logic [LW-1:0]    s1_line;
    pixel_t           s1_above2;
    pixel_t           s1_above1;
    logic             fwd_next;

    // Width register as used: clamped to 3 .. MAX_WIDTH.
    always_comb
    begin
        width_ext = CMPW'(width_reg);
        if (width_ext > CMPW'(MAX_WIDTH))
        begin
            eff_width = WW'(MAX_WIDTH);
        end
        else if (width_ext < CMPW'(MIN_WIDTH))
        begin
            eff_width = WW'(MIN_WIDTH);
        end
        else
        begin
            eff_width = WW'(width_ext);
        end
    end

    // Handshake: each stage moves when the one after it can take the item.
    assign out_adv  = !out_valid_reg || !out_stall;
    assign s3_free  = !s3_valid_reg || out_adv;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_adv   = s1_valid_reg && (!s1_emit_reg || s2_free);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign accept   = in_valid && !in_stall;

    // Position of the incoming pixel and its row/column bookkeeping.
    always_comb
    begin
        acc_col     = frame_start ? '0 : col_reg;
        acc_row     = frame_start ? 2'd0 : row_reg;
        acc_col_inc = WW'(acc_col) + WW'(1);
        acc_emit    = (acc_row == 2'd2) && (acc_col >= AW'(2));
        acc_row_end = (WW'(acc_col) == eff_width - WW'(1));
        col_next    = AW'(acc_col_inc);
        row_next    = acc_row;
        if (acc_col_inc >= eff_width)
        begin
            col_next = '0;
            if (acc_row != 2'd2)
            begin
                row_next = acc_row + 2'd1;
            end
        end
    end

    // Line stores: upper row in the high half, middle row in the low half.
    mf3_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data ({s1_above1, s1_pixel_reg}),
        .rd_en   (accept),
        .rd_addr (acc_col),
        .rd_data (ram_rd_data)
    );

    // Forward the write of the item ahead when it hits the same column.
    assign s1_line   = s1_fwd_reg ? s1_fwd_data_reg : ram_rd_data;
    assign s1_above2 = s1_line[LW-1:PIX_W];
    assign s1_above1 = s1_line[PIX_W-1:0];
    assign fwd_next  = s1_adv && (s1_col_reg == acc_col);

    // Window shifts left by one column; the new column enters on the right.
    always_comb
    begin
        win_next    = win_reg;
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[2] = s1_above2;
        win_next[5] = s1_above1;
        win_next[8] = s1_pixel_reg;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= CFG_W'(WIDTH_RESET);
            col_reg       <= '0;
            row_reg       <= 2'd0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                width_reg <= cfg_wdata;
            end
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_adv && s1_emit_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_adv)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Payload registers of every stage.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg    <= {in_red, in_green, in_blue};
            s1_col_reg      <= acc_col;
            s1_emit_reg     <= acc_emit;
            s1_row_end_reg  <= acc_row_end;
            s1_centre_reg   <= acc_col - AW'(1);
            s1_fwd_reg      <= fwd_next;
            s1_fwd_data_reg <= {s1_above1, s1_pixel_reg};
        end
        if (s1_adv)
        begin
            win_reg <= win_next;
        end
        if (s1_adv && s1_emit_reg)
        begin
            s2_win_reg     <= win_next;
            s2_row_end_reg <= s1_row_end_reg;
            s2_centre_reg  <= s1_centre_reg;
        end
        if (s2_valid_reg && s3_free)
        begin
            s3_red_reg     <= sort_rows(channel_of(s2_win_reg, CH_RED));
            s3_green_reg   <= sort_rows(channel_of(s2_win_reg, CH_GREEN));
            s3_blue_reg    <= sort_rows(channel_of(s2_win_reg, CH_BLUE));
            s3_row_end_reg <= s2_row_end_reg;
            s3_centre_reg  <= s2_centre_reg;
        end
        if (s3_valid_reg && out_adv)
        begin
            out_red_reg     <= median_tail(s3_red_reg);
            out_green_reg   <= median_tail(s3_green_reg);
            out_blue_reg    <= median_tail(s3_blue_reg);
            out_row_end_reg <= s3_row_end_reg;
            out_centre_reg  <= s3_centre_reg;
        end
    end

    // Output ports.
    assign out_valid     = out_valid_reg;
    assign out_red       = out_red_reg;
    assign out_green     = out_green_reg;
    assign out_blue      = out_blue_reg;
    assign centre_column = COL_OUT_W'(out_centre_reg);
    assign row_end       = out_row_end_reg;

endmodule

FILE: src/mf3_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds while rd_en is low.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule
